// File: sv/tlpe_pkg.sv
// ----------------------------------------------------------------------------
// tlpe_pkg
// Shared constants, command word, tables and color scaling for the LED
// target pattern engine.
// ----------------------------------------------------------------------------
package tlpe_pkg;

   localparam int LEDS_PER_RING = 35;
   localparam int TARGET_COUNT  = 6;
   localparam int PLAYER_REGS   = 6;
   localparam int QUEUE_DEPTH   = 4;

   localparam int TGT_W  = (TARGET_COUNT > 1) ? $clog2(TARGET_COUNT) : 1;
   localparam int PREG_W = $clog2(PLAYER_REGS);
   localparam int CSR_IDX_W = 3;
   localparam int PIX_W  = 6;
   localparam int PHASE_W = 6;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PIX_W-1:0] RING_LAST = PIX_W'(LEDS_PER_RING - 1);
   localparam logic [PHASE_W-1:0] PHASE_WRAP = PHASE_W'(LEDS_PER_RING);

   // request operation
   localparam logic OP_MESSAGE = 1'b0;
   localparam logic OP_RENDER  = 1'b1;

   // MIDI commands (status high nibble)
   localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
   localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
   localparam logic [3:0] MIDI_CTRL     = 4'hB;

   // pattern codes
   localparam logic [3:0] PAT_OFF     = 4'd0;
   localparam logic [3:0] PAT_FLASH   = 4'd1;
   localparam logic [3:0] PAT_SOLID   = 4'd2;
   localparam logic [3:0] PAT_ROTATE  = 4'd3;
   localparam logic [3:0] PAT_COUNTER = 4'd4;

   typedef logic [1:0] cmd_kind_type;
   localparam cmd_kind_type KIND_NOTE_OFF = 2'd0;
   localparam cmd_kind_type KIND_NOTE_ON  = 2'd1;
   localparam cmd_kind_type KIND_REPLY    = 2'd2;
   localparam cmd_kind_type KIND_RENDER   = 2'd3;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [TGT_W-1:0] target;
      logic [7:0]       status;
      logic [7:0]       data;   // note-on: {0, data2}; reply: data2 + targets
   } cmd_type;

   typedef struct packed {
      logic              full;
      logic [QCNT_W-1:0] count;
   } q_status_type;

   localparam logic [31:0] COLOR_RESET [PLAYER_REGS] = '{
      32'hFF000000, 32'h00FF0000, 32'h0000FF00,
      32'h60900000, 32'h00000000, 32'h88888800
   };

   function automatic logic [8:0] fade_level(input logic [PIX_W-1:0] idx);
      logic [8:0] lvl;
      case (idx)
         6'd14:   lvl = 9'd1;
         6'd15:   lvl = 9'd2;
         6'd16:   lvl = 9'd4;
         6'd17:   lvl = 9'd8;
         6'd18:   lvl = 9'd16;
         6'd19:   lvl = 9'd32;
         6'd20:   lvl = 9'd48;
         6'd21:   lvl = 9'd64;
         6'd22:   lvl = 9'd80;
         6'd23:   lvl = 9'd96;
         6'd24:   lvl = 9'd112;
         6'd25:   lvl = 9'd128;
         6'd26:   lvl = 9'd144;
         6'd27:   lvl = 9'd160;
         6'd28:   lvl = 9'd176;
         6'd29:   lvl = 9'd192;
         6'd30:   lvl = 9'd208;
         6'd31:   lvl = 9'd224;
         6'd32:   lvl = 9'd240;
         6'd33:   lvl = 9'd256;
         6'd34:   lvl = 9'd256;
         default: lvl = 9'd0;
      endcase
      return lvl;
   endfunction

   // one-shot decay; phases past the table read zero
   function automatic logic [8:0] flash_level(input logic [PHASE_W-1:0] ph);
      logic [8:0] lvl;
      case (ph)
         6'd0:    lvl = 9'd256;
         6'd1:    lvl = 9'd256;
         6'd2:    lvl = 9'd64;
         6'd3:    lvl = 9'd8;
         6'd4:    lvl = 9'd4;
         6'd5:    lvl = 9'd2;
         6'd6:    lvl = 9'd1;
         default: lvl = 9'd0;
      endcase
      return lvl;
   endfunction

   // (byte * b) >> 8 on G, R, B; white byte dropped
   function automatic logic [31:0] scale_color(input logic [31:0] c,
                                               input logic [8:0] b);
      logic [16:0] g;
      logic [16:0] r;
      logic [16:0] bl;
      g  = c[31:24] * b;
      r  = c[23:16] * b;
      bl = c[15:8] * b;
      return {g[15:8], r[15:8], bl[15:8], 8'h00};
   endfunction

endpackage

// File: sv/tlpe_front.sv
// ----------------------------------------------------------------------------
// tlpe_front
// Accepts request words, decodes the MIDI command, drops ignored items and
// pushes one command word per kept item into the queue.
// ----------------------------------------------------------------------------
module tlpe_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [7:0]            req_status_byte,
   input  logic [6:0]            req_data_one,
   input  logic [6:0]            req_data_two,
   input  logic [2:0]            req_render_target,
   input  tlpe_pkg::q_status_type q_status,
   output logic                  push,
   output tlpe_pkg::cmd_type     push_cmd
);
   import tlpe_pkg::*;

   logic [7:0] d1_ext;
   logic [7:0] rt_ext;
   logic       keep;

   assign d1_ext = {1'b0, req_data_one};
   assign rt_ext = {5'b0, req_render_target};

   always_comb begin
      keep            = 1'b0;
      push_cmd.kind   = KIND_RENDER;
      push_cmd.target = d1_ext[TGT_W-1:0];
      push_cmd.status = req_status_byte;
      push_cmd.data   = {1'b0, req_data_two};
      if (req_operation == OP_RENDER) begin
         keep            = (rt_ext < 8'(TARGET_COUNT));
         push_cmd.target = rt_ext[TGT_W-1:0];
      end else begin
         case (req_status_byte[7:4])
            MIDI_NOTE_OFF: begin
               keep          = (d1_ext < 8'(TARGET_COUNT));
               push_cmd.kind = KIND_NOTE_OFF;
            end
            MIDI_NOTE_ON: begin
               keep          = (d1_ext < 8'(TARGET_COUNT));
               push_cmd.kind = KIND_NOTE_ON;
            end
            MIDI_CTRL: begin
               keep          = 1'b1;
               push_cmd.kind = KIND_REPLY;
               push_cmd.data = {1'b0, req_data_two} + 8'(TARGET_COUNT);
            end
            default: keep = 1'b0;
         endcase
      end
   end

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full && keep;

endmodule

// File: sv/tlpe_queue.sv
// ----------------------------------------------------------------------------
// tlpe_queue
// Small command FIFO between the decoder and the pattern sequencer.
// ----------------------------------------------------------------------------
module tlpe_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tlpe_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output logic                   head_valid,
   output tlpe_pkg::cmd_type      head_cmd,
   output tlpe_pkg::q_status_type q_status
);
   import tlpe_pkg::*;

   cmd_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign head_valid     = (count_ff != '0);
   assign head_cmd       = queue_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.count = count_ff;
   assign do_pop         = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (!push && do_pop)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         queue_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/tlpe_back.sv
// ----------------------------------------------------------------------------
// tlpe_back
// Holds player colors and per-target state, executes queued commands and
// streams pixel or reply words through the output register.
// ----------------------------------------------------------------------------
module tlpe_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_en,
   input  logic [tlpe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]             csr_data,
   input  logic                    head_valid,
   input  tlpe_pkg::cmd_type       head_cmd,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [31:0]             rsp_pixel_color,
   output logic                    rsp_last_pixel,
   output logic                    rsp_reply_valid,
   output logic [7:0]              rsp_reply_status,
   output logic [6:0]              rsp_reply_data_one,
   output logic [7:0]              rsp_reply_data_two
);
   import tlpe_pkg::*;

   logic [31:0]        color_ff   [PLAYER_REGS];
   logic [3:0]         pattern_ff [TARGET_COUNT];
   logic [3:0]         player_ff  [TARGET_COUNT];
   logic [PHASE_W-1:0] phase_ff   [TARGET_COUNT];

   // render sequencer
   logic               busy_ff, busy_in;
   logic [PIX_W-1:0]   pix_ff, pix_in;
   logic [PIX_W-1:0]   idx_ff, idx_in;
   logic [3:0]         pat_ff, pat_in;
   logic [31:0]        col_ff, col_in;
   logic [8:0]         flash_ff, flash_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        color_out_ff, color_out_in;
   logic               last_ff, last_in;
   logic               reply_ff, reply_in;
   logic [7:0]         rstatus_ff, rstatus_in;
   logic [7:0]         rdata_ff, rdata_in;

   logic               out_free;
   logic               take;
   logic               emit;
   logic [3:0]         cur_pat;
   logic [3:0]         cur_player;
   logic [PHASE_W-1:0] cur_phase;
   logic [8:0]         level;
   logic [31:0]        pixel;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign take       = head_valid && !busy_ff && out_free;
   assign emit       = busy_ff && out_free;
   assign pop        = take;
   assign cur_pat    = pattern_ff[head_cmd.target];
   assign cur_player = player_ff[head_cmd.target];
   assign cur_phase  = phase_ff[head_cmd.target];

   always_comb begin
      level = (pat_ff == PAT_FLASH) ? flash_ff : fade_level(idx_ff);
      case (pat_ff)
         PAT_SOLID:                        pixel = col_ff;
         PAT_FLASH, PAT_ROTATE, PAT_COUNTER: pixel = scale_color(col_ff, level);
         default:                          pixel = '0;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      pix_in       = pix_ff;
      idx_in       = idx_ff;
      pat_in       = pat_ff;
      col_in       = col_ff;
      flash_in     = flash_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      color_out_in = color_out_ff;
      last_in      = last_ff;
      reply_in     = reply_ff;
      rstatus_in   = rstatus_ff;
      rdata_in     = rdata_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         color_out_in = pixel;
         last_in      = (pix_ff == RING_LAST);
         reply_in     = 1'b0;
         rstatus_in   = '0;
         rdata_in     = '0;
         pix_in       = pix_ff + 1'b1;
         if (pat_ff == PAT_ROTATE)
            idx_in = (idx_ff == '0) ? RING_LAST : idx_ff - 1'b1;
         else
            idx_in = (idx_ff == RING_LAST) ? '0 : idx_ff + 1'b1;
         if (pix_ff == RING_LAST)
            busy_in = 1'b0;
      end else if (take) begin
         case (head_cmd.kind)
            KIND_REPLY: begin
               rsp_valid_in = 1'b1;
               color_out_in = '0;
               last_in      = 1'b0;
               reply_in     = 1'b1;
               rstatus_in   = head_cmd.status;
               rdata_in     = head_cmd.data;
            end
            KIND_RENDER: begin
               busy_in  = 1'b1;
               pix_in   = '0;
               idx_in   = (cur_phase >= PHASE_WRAP) ? '0 : PIX_W'(cur_phase);
               pat_in   = (cur_pat > PAT_COUNTER) ? PAT_OFF : cur_pat;
               col_in   = (cur_player < 4'(PLAYER_REGS)) ?
                          color_ff[cur_player[PREG_W-1:0]] : '0;
               flash_in = flash_level(cur_phase);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLAYER_REGS; i++)
            color_ff[i] <= COLOR_RESET[i];
      end else if (csr_write_en && (csr_index < CSR_IDX_W'(PLAYER_REGS))) begin
         color_ff[csr_index[PREG_W-1:0]] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TARGET_COUNT; i++) begin
            pattern_ff[i] <= PAT_OFF;
            player_ff[i]  <= '0;
            phase_ff[i]   <= '0;
         end
      end else if (take) begin
         case (head_cmd.kind)
            KIND_NOTE_OFF: begin
               pattern_ff[head_cmd.target] <= PAT_OFF;
               phase_ff[head_cmd.target]   <= '0;
            end
            KIND_NOTE_ON: begin
               player_ff[head_cmd.target]  <= head_cmd.data[7:4];
               pattern_ff[head_cmd.target] <= head_cmd.data[3:0];
            end
            KIND_RENDER: begin
               case (cur_pat)
                  PAT_FLASH: begin
                     if (cur_phase >= PHASE_WRAP)
                        pattern_ff[head_cmd.target] <= PAT_OFF;
                     else
                        phase_ff[head_cmd.target] <= cur_phase + 1'b1;
                  end
                  PAT_ROTATE, PAT_COUNTER:
                     phase_ff[head_cmd.target] <=
                        (cur_phase >= PHASE_WRAP) ? '0 : cur_phase + 1'b1;
                  PAT_SOLID: ;
                  default:   phase_ff[head_cmd.target] <= '0;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff       <= pix_in;
      idx_ff       <= idx_in;
      pat_ff       <= pat_in;
      col_ff       <= col_in;
      flash_ff     <= flash_in;
      color_out_ff <= color_out_in;
      last_ff      <= last_in;
      reply_ff     <= reply_in;
      rstatus_ff   <= rstatus_in;
      rdata_ff     <= rdata_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_color    = color_out_ff;
   assign rsp_last_pixel     = last_ff;
   assign rsp_reply_valid    = reply_ff;
   assign rsp_reply_status   = rstatus_ff;
   assign rsp_reply_data_one = '0;
   assign rsp_reply_data_two = rdata_ff;

endmodule

// File: sv/target_led_pattern_engine.sv
// ----------------------------------------------------------------------------
// target_led_pattern_engine
// Per-target LED pattern state driven by MIDI words; renders one ring of
// pixel colors per render word.
//
//   port group   dir   handshake           contents
//   req_*        in    req_valid/stall     operation, MIDI bytes, target
//   rsp_*        out   rsp_valid/stall     pixel color or control reply
//   csr_*        in    csr_write_en        player color registers 0..5
//
// A render in the sequencer first loads the target, then emits 35 pixels at
// one per cycle unless rsp_stall holds the output. Note words update state.
// A 4-word command queue decouples the request side from the sequencer.
// Reset is synchronous: colors go to defaults, all target state to zero.
// rsp_stall freezes a valid output word and the sequencer; req_stall rises
// only when the queue is full.
// ----------------------------------------------------------------------------
module target_led_pattern_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_status_byte,
   input  logic [6:0]  req_data_one,
   input  logic [6:0]  req_data_two,
   input  logic [2:0]  req_render_target,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_color,
   output logic        rsp_last_pixel,
   output logic        rsp_reply_valid,
   output logic [7:0]  rsp_reply_status,
   output logic [6:0]  rsp_reply_data_one,
   output logic [7:0]  rsp_reply_data_two,
   input  logic        csr_write_en,
   input  logic [tlpe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import tlpe_pkg::*;

   logic         push;
   cmd_type      push_cmd;
   logic         pop;
   logic         head_valid;
   cmd_type      head_cmd;
   q_status_type q_status;

   tlpe_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_status_byte   (req_status_byte),
      .req_data_one      (req_data_one),
      .req_data_two      (req_data_two),
      .req_render_target (req_render_target),
      .q_status          (q_status),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   tlpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .q_status   (q_status)
   );

   tlpe_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .head_valid         (head_valid),
      .head_cmd           (head_cmd),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_color    (rsp_pixel_color),
      .rsp_last_pixel     (rsp_last_pixel),
      .rsp_reply_valid    (rsp_reply_valid),
      .rsp_reply_status   (rsp_reply_status),
      .rsp_reply_data_one (rsp_reply_data_one),
      .rsp_reply_data_two (rsp_reply_data_two)
   );

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output word valid right after reset");

   a_reply_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reply_valid) |-> (rsp_pixel_color == 32'd0 && !rsp_last_pixel))
      else $error("control reply carries pixel data");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue overflow");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("command pushed into full queue");

endmodule

// File: verif/tlpe_checker.sv
// ----------------------------------------------------------------------------
// tlpe_checker
// Passive checker for the LED target pattern engine. Keeps its own copy of
// the player colors and of the pattern, player and phase of every target,
// works out the result words of each accepted request word and compares
// every accepted result word, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module tlpe_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_operation,
   input  logic [7:0]                     req_status_byte,
   input  logic [6:0]                     req_data_one,
   input  logic [6:0]                     req_data_two,
   input  logic [2:0]                     req_render_target,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [31:0]                    rsp_pixel_color,
   input  logic                           rsp_last_pixel,
   input  logic                           rsp_reply_valid,
   input  logic [7:0]                     rsp_reply_status,
   input  logic [6:0]                     rsp_reply_data_one,
   input  logic [7:0]                     rsp_reply_data_two,
   input  logic                           csr_write_en,
   input  logic [tlpe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data,
   output int                             fail_count,
   output int                             words_pending
);
   import tlpe_pkg::*;

   typedef struct {
      logic [31:0] pixel_color;
      logic        last_pixel;
      logic        reply_valid;
      logic [7:0]  reply_status;
      logic [6:0]  reply_data_one;
      logic [7:0]  reply_data_two;
   } ring_word_type;

   ring_word_type owed_words[$];
   logic [31:0] color_bank [PLAYER_REGS];
   logic [3:0]  pattern_of [TARGET_COUNT];
   logic [3:0]  player_of  [TARGET_COUNT];
   logic [5:0]  phase_of   [TARGET_COUNT];

   // fade ramp: dark, then doubling 1..32, then steps of 16 up to full
   function automatic logic [8:0] fade_gain(input int idx);
      if (idx < 14) return 9'd0;
      if (idx < 20) return 9'(1 << (idx - 14));
      if (idx < 33) return 9'((idx - 17) * 16);
      return 9'd256;
   endfunction

   function automatic logic [8:0] flash_gain(input logic [5:0] ph);
      int p;
      p = ph;
      if (p < 2) return 9'd256;
      if (p == 2) return 9'd64;
      if (p < 7) return 9'(1 << (6 - p));
      return 9'd0;
   endfunction

   // G, R and B scaled by gain/256, white byte cleared
   function automatic logic [31:0] dim(input logic [31:0] c, input logic [8:0] gain);
      logic [31:0] res;
      res = '0;
      for (int k = 1; k < 4; k++)
         res[k*8 +: 8] = 8'((32'(c[k*8 +: 8]) * 32'(gain)) >> 8);
      return res;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      fail_count++;
      if (fail_count <= 40)
         $display("%0t: mismatch in %s: got %h, want %h", $time, what, got, want);
   endtask

   task automatic step_targets();
      int            tgt;
      int            ph;
      logic [3:0]    pat;
      logic [31:0]   col;
      ring_word_type w;
      w.pixel_color    = '0;
      w.last_pixel     = 1'b0;
      w.reply_valid    = 1'b0;
      w.reply_status   = '0;
      w.reply_data_one = '0;
      w.reply_data_two = '0;
      if (req_operation != OP_RENDER) begin
         tgt = req_data_one;
         case (req_status_byte[7:4])
            MIDI_NOTE_OFF: if (tgt < TARGET_COUNT) begin
               pattern_of[tgt] = PAT_OFF;
               phase_of[tgt]   = '0;
            end
            MIDI_NOTE_ON: if (tgt < TARGET_COUNT) begin
               player_of[tgt]  = {1'b0, req_data_two[6:4]};
               pattern_of[tgt] = req_data_two[3:0];
            end
            MIDI_CTRL: begin
               w.reply_valid    = 1'b1;
               w.reply_status   = req_status_byte;
               w.reply_data_two = 8'(req_data_two + TARGET_COUNT);
               owed_words.push_back(w);
            end
            default: ;
         endcase
         return;
      end

      tgt = req_render_target;
      if (tgt >= TARGET_COUNT) return;
      pat = pattern_of[tgt];
      ph  = phase_of[tgt];
      col = (player_of[tgt] < PLAYER_REGS) ? color_bank[player_of[tgt]] : '0;
      for (int i = 0; i < LEDS_PER_RING; i++) begin
         case (pat)
            PAT_FLASH:   w.pixel_color = dim(col, flash_gain(6'(ph)));
            PAT_SOLID:   w.pixel_color = col;
            PAT_ROTATE:  w.pixel_color = dim(col,
                            fade_gain((ph + LEDS_PER_RING - i) % LEDS_PER_RING));
            PAT_COUNTER: w.pixel_color = dim(col, fade_gain((ph + i) % LEDS_PER_RING));
            default:     w.pixel_color = '0;
         endcase
         w.last_pixel = (i == LEDS_PER_RING - 1);
         owed_words.push_back(w);
      end

      case (pat)
         PAT_FLASH: begin
            // one-shot: once past the ring it drops to off, phase left as is
            if (ph >= LEDS_PER_RING) pattern_of[tgt] = PAT_OFF;
            else phase_of[tgt] = 6'(ph + 1);
         end
         PAT_SOLID: ;
         PAT_ROTATE, PAT_COUNTER: phase_of[tgt] = (ph >= LEDS_PER_RING) ? '0 : 6'(ph + 1);
         default: phase_of[tgt] = '0;
      endcase
   endtask

   always @(posedge clock) begin
      ring_word_type want;
      if (reset) begin
         fail_count = 0;
         owed_words.delete();
         color_bank = '{32'hFF000000, 32'h00FF0000, 32'h0000FF00,
                        32'h60900000, 32'h00000000, 32'h88888800};
         for (int t = 0; t < TARGET_COUNT; t++) begin
            pattern_of[t] = PAT_OFF;
            player_of[t]  = '0;
            phase_of[t]   = '0;
         end
      end else begin
         if (csr_write_en && csr_index < PLAYER_REGS)
            color_bank[csr_index] = csr_data;
         // result side first: a word accepted at this edge cannot be its own answer
         if (rsp_valid && !rsp_stall) begin
            if (owed_words.size() == 0) begin
               report("word with nothing owed", rsp_pixel_color, '0);
            end else begin
               want = owed_words.pop_front();
               if (rsp_pixel_color !== want.pixel_color)
                  report("pixel_color", rsp_pixel_color, want.pixel_color);
               if (rsp_last_pixel !== want.last_pixel)
                  report("last_pixel", 32'(rsp_last_pixel), 32'(want.last_pixel));
               if (rsp_reply_valid !== want.reply_valid)
                  report("reply_valid", 32'(rsp_reply_valid), 32'(want.reply_valid));
               if (rsp_reply_status !== want.reply_status)
                  report("reply_status", 32'(rsp_reply_status), 32'(want.reply_status));
               if (rsp_reply_data_one !== want.reply_data_one)
                  report("reply_data_one", 32'(rsp_reply_data_one), 32'(want.reply_data_one));
               if (rsp_reply_data_two !== want.reply_data_two)
                  report("reply_data_two", 32'(rsp_reply_data_two), 32'(want.reply_data_two));
            end
         end
         if (req_valid && !req_stall) step_targets();
      end
      words_pending = owed_words.size();
   end

endmodule

// File: verif/tb_target_led_pattern_engine.sv
// ----------------------------------------------------------------------------
// tb_target_led_pattern_engine
// Drives MIDI and render words into the LED target pattern engine with
// random gaps and output stalls, under several player color settings, and
// leaves prediction and comparison to tlpe_checker.
// ----------------------------------------------------------------------------
module tb_target_led_pattern_engine;
   import tlpe_pkg::*;

   localparam int   HOLD_CYCLES = 400;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_operation     = 1'b0;
   logic [7:0]           req_status_byte   = '0;
   logic [6:0]           req_data_one      = '0;
   logic [6:0]           req_data_two      = '0;
   logic [2:0]           req_render_target = '0;
   logic                 rsp_stall         = 1'b0;
   logic                 csr_write_en      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index         = '0;
   logic [31:0]          csr_data          = '0;
   logic                 req_stall;
   logic                 rsp_valid;
   logic [31:0]          rsp_pixel_color;
   logic                 rsp_last_pixel;
   logic                 rsp_reply_valid;
   logic [7:0]           rsp_reply_status;
   logic [6:0]           rsp_reply_data_one;
   logic [7:0]           rsp_reply_data_two;
   int                   fail_count;
   int                   words_pending;

   bit no_idle   = 1'b0;
   bit long_hold = 1'b0;
   bit hold_done = 1'b0;
   int useful_words  = 0;
   int render_words  = 0;
   int message_words = 0;
   int settings      = 1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   target_led_pattern_engine u_top (.*);

   tlpe_checker u_check (.*);

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // valid stays high into the next word unless a gap follows
   task automatic send_word(input logic op, input logic [7:0] status,
                            input logic [6:0] d1, input logic [6:0] d2,
                            input logic [2:0] tgt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_status_byte   <= status;
      req_data_one      <= d1;
      req_data_two      <= d2;
      req_render_target <= tgt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (op == OP_RENDER) begin
         if (tgt < TARGET_COUNT) begin
            useful_words++;
            render_words++;
         end
      end else if (status[7:4] == MIDI_CTRL ||
                   ((status[7:4] == MIDI_NOTE_ON || status[7:4] == MIDI_NOTE_OFF) &&
                    d1 < TARGET_COUNT)) begin
         useful_words++;
         message_words++;
      end
   endtask

   task automatic message(input logic [3:0] cmd, input logic [3:0] chan,
                          input logic [6:0] d1, input logic [6:0] d2);
      send_word(OP_MESSAGE, {cmd, chan}, d1, d2, 3'($urandom));
   endtask

   task automatic note_on(input logic [6:0] tgt, input logic [2:0] player,
                          input logic [3:0] pattern);
      message(MIDI_NOTE_ON, 4'($urandom), tgt, {player, pattern});
   endtask

   task automatic render(input logic [2:0] tgt);
      send_word(OP_RENDER, 8'($urandom), 7'($urandom), 7'($urandom), tgt);
   endtask

   // wait for the block to drain before touching the color registers
   task automatic settle();
      req_valid <= 1'b0;
      for (int w = 0; w < 50000 && words_pending != 0; w++) @(negedge clock);
      repeat (48) @(negedge clock);
   endtask

   task automatic load_colors(input logic [31:0] colors [PLAYER_REGS]);
      for (int i = 0; i < 2**CSR_IDX_W; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= CSR_IDX_W'(i);
         csr_data     <= (i < PLAYER_REGS) ? colors[i] : 32'($urandom);
         @(negedge clock);
      end
      csr_write_en <= 1'b0;
      settings++;
   endtask

   task automatic random_traffic(input int n);
      int goal;
      int pick;
      int tgt;
      int reps;
      goal = useful_words + n;
      while (useful_words < goal) begin
         pick = $urandom_range(0, 99);
         tgt  = $urandom_range(0, TARGET_COUNT - 1);
         if (pick < 45) begin
            note_on(7'(tgt), 3'($urandom),
                    ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4)));
            // long bursts walk a flash past its end and a fade through its wrap
            reps = ($urandom_range(0, 3) == 0) ? $urandom_range(36, 42) : $urandom_range(1, 6);
            repeat (reps) render(3'(tgt));
         end else if (pick < 60) begin
            render(3'($urandom));
         end else if (pick < 70) begin
            message(MIDI_CTRL, 4'($urandom), 7'($urandom), 7'($urandom));
         end else if (pick < 80) begin
            message(MIDI_NOTE_OFF, 4'($urandom),
                    ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'(tgt), 7'($urandom));
         end else begin
            send_word(OP_MESSAGE, 8'($urandom), 7'($urandom), 7'($urandom), 3'($urandom));
         end
      end
   endtask

   initial begin : rsp_stall_gen
      forever begin
         @(negedge clock);
         if (long_hold && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
            rsp_stall <= 1'b0;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 299) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(15, 50)) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 25);
         end
      end
   end

   initial begin : stimulus
      logic [31:0] colors [PLAYER_REGS];
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words under the reset colors
      message(MIDI_CTRL, 4'h0, 7'd0, 7'd0);
      message(MIDI_CTRL, 4'hF, 7'h7F, 7'h7F);
      note_on(7'd0, 3'd0, PAT_SOLID);
      render(3'd0);
      note_on(7'd1, 3'd5, PAT_FLASH);
      render(3'd1);
      render(3'd1);
      note_on(7'd2, 3'd3, PAT_ROTATE);
      render(3'd2);
      note_on(7'd3, 3'd1, PAT_COUNTER);
      render(3'd3);
      note_on(7'd4, 3'd7, PAT_SOLID);     // player without a register: black
      render(3'd4);
      note_on(7'd5, 3'd2, 4'hF);          // unused pattern acts as off
      render(3'd5);
      note_on(7'(TARGET_COUNT), 3'd1, PAT_SOLID);
      note_on(7'h7F, 3'd1, PAT_SOLID);
      message(MIDI_NOTE_OFF, 4'h3, 7'h7F, 7'h55);
      render(3'(TARGET_COUNT));
      render(3'h7);
      message(MIDI_NOTE_OFF, 4'h0, 7'd1, 7'd0);
      render(3'd1);
      message(4'hA, 4'h0, 7'd0, 7'd0);
      message(4'h0, 4'h0, 7'd2, 7'h12);
      message(4'hF, 4'hF, 7'h7F, 7'h7F);

      settle();
      for (int i = 0; i < PLAYER_REGS; i++) colors[i] = '1;
      load_colors(colors);
      random_traffic(50);

      // block fills up behind a long output hold
      settle();
      for (int i = 0; i < PLAYER_REGS; i++) colors[i] = $urandom;
      load_colors(colors);
      long_hold = 1'b1;
      random_traffic(50);

      settle();
      for (int i = 0; i < PLAYER_REGS; i++) colors[i] = (i % 2 == 0) ? '0 : '1;
      load_colors(colors);
      no_idle = 1'b1;
      random_traffic(40);
      no_idle = 1'b0;

      settle();
      for (int i = 0; i < PLAYER_REGS; i++) colors[i] = $urandom;
      load_colors(colors);
      random_traffic(60);

      settle();
      repeat (40) @(negedge clock);
      $display("covered %0d effective words (%0d renders, %0d note/control messages)",
               useful_words, render_words, message_words);
      $display("under %0d color settings, with one %0d-cycle output hold",
               settings, HOLD_CYCLES);
      if (words_pending != 0) $display("%0d result words never arrived", words_pending);
      if (fail_count == 0 && words_pending == 0) begin
         $display("tb_target_led_pattern_engine OK");
      end else begin
         $display("tb_target_led_pattern_engine NOT OK");
      end
      $finish;
   end

   initial begin : watchdog
      #(8 * 400000);
      $display("run timed out");
      $display("tb_target_led_pattern_engine NOT OK");
      $finish;
   end

endmodule
